// ===== rtl/rlk_pkg.sv =====
`timescale 1ns / 1ps

package rlk_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int NUM_PORTS_DEF   = 4;

  localparam int ADDR_W    = 32;
  localparam int IDX_IN_W  = 4;
  localparam int PORT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_EXT_W = 9;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  typedef struct packed {
    logic         en;
    logic         valid;
    route_entry_t entry;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/rlk_req_if.sv =====
`timescale 1ns / 1ps

interface rlk_req_if;
  import rlk_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [IDX_IN_W-1:0] entry_index;
  logic [ADDR_W-1:0]   route_dest;
  logic [ADDR_W-1:0]   route_mask;
  logic [ADDR_W-1:0]   route_gateway;
  logic [PORT_W-1:0]   route_port;
  logic                route_enable;
  logic [ADDR_W-1:0]   lookup_addr;

  modport source (
    output valid, req_type, entry_index, route_dest, route_mask, route_gateway,
           route_port, route_enable, lookup_addr,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, route_dest, route_mask, route_gateway,
           route_port, route_enable, lookup_addr,
    output ready
  );
endinterface

// ===== rtl/rlk_rsp_if.sv =====
`timescale 1ns / 1ps

interface rlk_rsp_if;
  import rlk_pkg::*;

  logic                valid;
  logic                ready;
  logic                is_local;
  logic                route_found;
  logic [IDX_IN_W-1:0] match_index;
  logic [ADDR_W-1:0]   next_hop_addr;
  logic [PORT_W-1:0]   out_port;

  modport source (
    output valid, is_local, route_found, match_index, next_hop_addr, out_port,
    input  ready
  );

  modport sink (
    input  valid, is_local, route_found, match_index, next_hop_addr, out_port,
    output ready
  );
endinterface

// ===== rtl/rlk_table.sv =====
`timescale 1ns / 1ps

module rlk_table #(
  parameter int DEPTH = rlk_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rlk_pkg::tbl_wr_t     wr_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output rlk_pkg::route_entry_t rd_entry_o,
  output logic                 rd_valid_o
);
  import rlk_pkg::*;

  route_entry_t     mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  route_entry_t     rd_entry_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx_i] <= wr_i.entry;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_idx_i] <= wr_i.valid;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== rtl/ipv4_route_lookup_lpm.sv =====
// A route write goes from acceptance to the done state, then into the output register once it is free.
// A lookup scans the table memory, which yields one slot per cycle, and then enters the done state.
// A new item is accepted only in the idle state, after the last one has left the done state.
// A finished result may wait in the output register while the next item is accepted.
// Reset clears the valid bits and the interface addresses at once; there is no clearing pass.
`timescale 1ns / 1ps

module ipv4_route_lookup_lpm #(
  parameter int TABLE_DEPTH = rlk_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_PORTS   = rlk_pkg::NUM_PORTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rlk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rlk_pkg::ADDR_W-1:0]    cfg_data_i,
  rlk_req_if.sink                       req_i,
  rlk_rsp_if.source                     rsp_o
);
  import rlk_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IF_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  iface_q [NUM_PORTS];
  logic [ADDR_W-1:0]  addr_q;
  logic               local_q;
  logic [IDX_W-1:0]   cnt_q;
  logic               issued_q;
  logic               rd_vld_q;
  logic               rd_last_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               found_q;
  logic [ADDR_W-1:0]  best_mask_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [ADDR_W-1:0]  best_gw_q;
  logic [PORT_W-1:0]  best_port_q;

  logic               out_valid_q;
  logic               out_local_q;
  logic               out_found_q;
  logic [IDX_IN_W-1:0] out_idx_q;
  logic [ADDR_W-1:0]  out_gw_q;
  logic [PORT_W-1:0]  out_port_q;

  logic               accept;
  logic               rd_en;
  logic               out_free;
  logic               load_out;
  logic               addr_local;
  logic               hit;
  logic               take;
  logic [IDX_EXT_W-1:0] ent_ext;
  logic [IDX_EXT_W-1:0] best_ext;
  logic               wr_in_range;
  tbl_wr_t            tbl_wr;
  route_entry_t       rd_entry;
  logic               rd_valid;

  always_comb begin
    addr_local = 1'b0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (iface_q[i] == req_i.lookup_addr) begin
        addr_local = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.req_type == REQ_LOOKUP) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && rd_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    rd_en       = (state_q == ST_SCAN) && !issued_q;
    out_free    = !out_valid_q || rsp_o.ready;
    load_out    = (state_q == ST_DONE) && out_free;
  end

  assign accept      = req_i.valid && req_i.ready;
  assign ent_ext     = IDX_EXT_W'(req_i.entry_index);
  assign wr_in_range = ent_ext < IDX_EXT_W'(TABLE_DEPTH);
  assign best_ext    = IDX_EXT_W'(best_idx_q);

  always_comb begin
    tbl_wr.en            = accept && (req_i.req_type == REQ_WRITE) && wr_in_range;
    tbl_wr.valid         = req_i.route_enable;
    tbl_wr.entry.dest    = req_i.route_dest;
    tbl_wr.entry.mask    = req_i.route_mask;
    tbl_wr.entry.gateway = req_i.route_gateway;
    tbl_wr.entry.port    = req_i.route_port;
  end

  rlk_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tbl_wr),
    .wr_idx_i   (ent_ext[IDX_W-1:0]),
    .rd_en_i    (rd_en),
    .rd_addr_i  (cnt_q),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid)
  );

  assign hit  = rd_valid && ((addr_q & rd_entry.mask) == rd_entry.dest);
  assign take = rd_vld_q && hit && (!found_q || (rd_entry.mask >= best_mask_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        iface_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_en;
      rd_last_q <= rd_en && (cnt_q == LAST_IDX);
      if (cfg_we_i && (3'(cfg_idx_i) < 3'(NUM_PORTS))) begin
        iface_q[cfg_idx_i[IF_W-1:0]] <= cfg_data_i;
      end
      if (accept) begin
        cnt_q    <= '0;
        issued_q <= 1'b0;
        found_q  <= 1'b0;
      end else begin
        if (rd_en) begin
          if (cnt_q == LAST_IDX) begin
            issued_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (accept) begin
      addr_q  <= req_i.lookup_addr;
      local_q <= (req_i.req_type == REQ_LOOKUP) && addr_local;
    end
    if (take) begin
      best_mask_q <= rd_entry.mask;
      best_idx_q  <= rd_idx_q;
      best_gw_q   <= rd_entry.gateway;
      best_port_q <= rd_entry.port;
    end
    if (load_out) begin
      out_local_q <= local_q;
      out_found_q <= found_q;
      out_idx_q   <= found_q ? best_ext[IDX_IN_W-1:0] : '0;
      out_gw_q    <= found_q ? best_gw_q : '0;
      out_port_q  <= found_q ? best_port_q : '0;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.is_local      = out_local_q;
  assign rsp_o.route_found   = out_found_q;
  assign rsp_o.match_index   = out_idx_q;
  assign rsp_o.next_hop_addr = out_gw_q;
  assign rsp_o.out_port      = out_port_q;

  a_no_route_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.route_found) |->
      (rsp_o.match_index == '0 && rsp_o.next_hop_addr == '0 && rsp_o.out_port == '0))
    else $error("Result without a route carries non-zero route fields.");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (state_q == ST_SCAN))
    else $error("Table read issued outside a scan.");

  a_idle_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rd_vld_q)
    else $error("Table data still arriving while idle.");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && rsp_o.valid && !rsp_o.ready) |=> (state_q == ST_DONE))
    else $error("Result left the done state while the output was stalled.");

endmodule

// ===== bench/ipv4_route_lookup_lpm_test.sv =====
`timescale 1ns / 1ps

module ipv4_route_lookup_lpm_test;
  import rlk_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int NUM_PORTS   = NUM_PORTS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 250;

  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_ADDR_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_ADDR_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_ADDR_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_ADDR_3 = 2'd3;

  typedef struct packed {
    logic                req_type;
    logic [IDX_IN_W-1:0] entry_index;
    logic [ADDR_W-1:0]   route_dest;
    logic [ADDR_W-1:0]   route_mask;
    logic [ADDR_W-1:0]   route_gateway;
    logic [PORT_W-1:0]   route_port;
    logic                route_enable;
    logic [ADDR_W-1:0]   lookup_addr;
  } route_req_t;

  typedef struct packed {
    logic                is_local;
    logic                route_found;
    logic [IDX_IN_W-1:0] match_index;
    logic [ADDR_W-1:0]   next_hop_addr;
    logic [PORT_W-1:0]   out_port;
  } route_rsp_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ADDR_W-1:0]    cfg_data_i;

  rlk_req_if req_if ();
  rlk_rsp_if rsp_if ();

  ipv4_route_lookup_lpm u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic [ADDR_W-1:0] iface_addr [NUM_PORTS];
  logic [ADDR_W-1:0] tbl_dest   [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_mask   [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_gw     [TABLE_DEPTH];
  logic [PORT_W-1:0] tbl_port   [TABLE_DEPTH];
  logic              tbl_valid  [TABLE_DEPTH];
  logic [ADDR_W-1:0] net_base   [4];

  route_rsp_t pending_rsp [$];
  int         mismatch_cnt = 0;
  int         burst_left   = 0;
  int         stall_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Forwarding decision for one item; route writes update the shadow table.
  function automatic route_rsp_t forward_request(input route_req_t r);
    route_rsp_t        res;
    logic [ADDR_W-1:0] best_mask;
    res       = '0;
    best_mask = '0;
    if (r.req_type == REQ_WRITE) begin
      tbl_dest[r.entry_index]  = r.route_dest;
      tbl_mask[r.entry_index]  = r.route_mask;
      tbl_gw[r.entry_index]    = r.route_gateway;
      tbl_port[r.entry_index]  = r.route_port;
      tbl_valid[r.entry_index] = r.route_enable;
      return res;
    end
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (iface_addr[p] == r.lookup_addr) res.is_local = 1'b1;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && ((r.lookup_addr & tbl_mask[i]) == tbl_dest[i]) &&
          (!res.route_found || tbl_mask[i] >= best_mask)) begin
        res.route_found   = 1'b1;
        res.match_index   = IDX_IN_W'(i);
        res.next_hop_addr = tbl_gw[i];
        res.out_port      = tbl_port[i];
        best_mask         = tbl_mask[i];
      end
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  function automatic route_req_t random_request();
    route_req_t r;
    int         pick;
    int         slot;
    r.req_type      = ($urandom_range(0, 9) < 3) ? REQ_WRITE : REQ_LOOKUP;
    r.entry_index   = IDX_IN_W'($urandom_range(0, TABLE_DEPTH - 1));
    r.route_mask    = ($urandom_range(0, 9) < 7) ? prefix_mask($urandom_range(0, 32)) : $urandom;
    r.route_dest    = ($urandom_range(0, 9) < 8) ?
                      ((net_base[$urandom_range(0, 3)] ^ ($urandom & 32'h0000_ffff)) &
                       r.route_mask) : $urandom;
    r.route_gateway = $urandom;
    r.route_port    = PORT_W'($urandom);
    r.route_enable  = ($urandom_range(0, 7) != 0);
    pick            = $urandom_range(0, 9);
    slot            = $urandom_range(0, TABLE_DEPTH - 1);
    if (pick < 6 && tbl_valid[slot]) begin
      r.lookup_addr = (tbl_dest[slot] & tbl_mask[slot]) | ($urandom & ~tbl_mask[slot]);
    end else if (pick < 8) begin
      r.lookup_addr = iface_addr[$urandom_range(0, NUM_PORTS - 1)];
    end else begin
      r.lookup_addr = $urandom;
    end
    return r;
  endfunction

  task automatic send_request(input route_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid         <= 1'b1;
    req_if.req_type      <= r.req_type;
    req_if.entry_index   <= r.entry_index;
    req_if.route_dest    <= r.route_dest;
    req_if.route_mask    <= r.route_mask;
    req_if.route_gateway <= r.route_gateway;
    req_if.route_port    <= r.route_port;
    req_if.route_enable  <= r.route_enable;
    req_if.lookup_addr   <= r.lookup_addr;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsp.push_back(forward_request(r));
  endtask

  task automatic write_route(input int slot, input logic [ADDR_W-1:0] dest,
                             input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] gw,
                             input logic [PORT_W-1:0] port, input logic enable);
    route_req_t r;
    r               = random_request();
    r.req_type      = REQ_WRITE;
    r.entry_index   = IDX_IN_W'(slot);
    r.route_dest    = dest;
    r.route_mask    = mask;
    r.route_gateway = gw;
    r.route_port    = port;
    r.route_enable  = enable;
    send_request(r);
  endtask

  task automatic lookup_route(input logic [ADDR_W-1:0] addr);
    route_req_t r;
    r             = random_request();
    r.req_type    = REQ_LOOKUP;
    r.lookup_addr = addr;
    send_request(r);
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    iface_addr[idx] = data;
  endtask

  task automatic set_iface_addrs(input logic [ADDR_W-1:0] a0, input logic [ADDR_W-1:0] a1,
                                 input logic [ADDR_W-1:0] a2, input logic [ADDR_W-1:0] a3);
    wait_idle();
    write_cfg(CFG_IFACE_ADDR_0, a0);
    write_cfg(CFG_IFACE_ADDR_1, a1);
    write_cfg(CFG_IFACE_ADDR_2, a2);
    write_cfg(CFG_IFACE_ADDR_3, a3);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    lookup_route('0);
    lookup_route('1);
    lookup_route($urandom);
  endtask

  task automatic test_directed_routes();
    set_iface_addrs(32'h0a00_0001, 32'hc0a8_0101, 32'hffff_ffff, 32'h0000_0000);
    lookup_route(32'h0a00_0001);
    write_route(0, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 2'd3, 1'b1);
    lookup_route(32'hffff_ffff);
    write_route(15, 32'hc0a8_0000, 32'hffff_0000, 32'h0a00_0002, 2'd1, 1'b1);
    lookup_route(32'hc0a8_0105);
    write_route(7, 32'hc0a8_0100, 32'hffff_ff00, 32'h0102_0304, 2'd2, 1'b1);
    lookup_route(32'hc0a8_0105);
    write_route(9, 32'hc0a8_0100, 32'hffff_ff00, 32'h0506_0708, 2'd0, 1'b1);
    lookup_route(32'hc0a8_01ff);
    write_route(9, 32'hc0a8_0100, 32'hffff_ff00, 32'hdead_0000, 2'd3, 1'b0);
    lookup_route(32'hc0a8_0101);
    write_route(3, 32'h0a00_00ff, 32'hffff_ff00, 32'h1111_1111, 2'd1, 1'b1);
    lookup_route(32'h0a00_00ff);
    write_route(4, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 2'd0, 1'b1);
    lookup_route(32'hffff_ffff);
    write_route(5, 32'h8000_0001, 32'h8000_0001, 32'h2222_2222, 2'd2, 1'b1);
    lookup_route(32'h8000_0001);
    write_route(0, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 2'd3, 1'b0);
    lookup_route(32'h1234_5678);
    lookup_route(32'h0000_0000);
  endtask

  task automatic test_random_traffic(input logic [ADDR_W-1:0] a0, input logic [ADDR_W-1:0] a1,
                                     input logic [ADDR_W-1:0] a2, input logic [ADDR_W-1:0] a3);
    set_iface_addrs(a0, a1, a2, a3);
    for (int b = 0; b < 4; b++) net_base[b] = $urandom;
    repeat (PHASE_ITEMS) send_request(random_request());
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= '0;
    cfg_data_i           <= '0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_WRITE;
    req_if.entry_index   <= '0;
    req_if.route_dest    <= '0;
    req_if.route_mask    <= '0;
    req_if.route_gateway <= '0;
    req_if.route_port    <= '0;
    req_if.route_enable  <= 1'b0;
    req_if.lookup_addr   <= '0;
    for (int p = 0; p < NUM_PORTS; p++) iface_addr[p] = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    for (int b = 0; b < 4; b++) net_base[b] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_routes();
    test_random_traffic('0, '0, '0, '0);
    test_random_traffic('1, '1, '1, '1);
    test_random_traffic($urandom, $urandom, $urandom, $urandom);
    test_random_traffic('0, '1, $urandom, $urandom);
    test_random_traffic($urandom, $urandom, $urandom, $urandom);

    wait_idle();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The receiver switches between free flow, random stalls and long stalls.
  initial begin
    int mode;
    int span;
    rsp_if.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          default: rsp_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    route_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result item with no request outstanding");
        mismatch_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("is_local", ADDR_W'(want.is_local), ADDR_W'(rsp_if.is_local));
        check_field("route_found", ADDR_W'(want.route_found), ADDR_W'(rsp_if.route_found));
        check_field("match_index", ADDR_W'(want.match_index), ADDR_W'(rsp_if.match_index));
        check_field("next_hop_addr", want.next_hop_addr, rsp_if.next_hop_addr);
        check_field("out_port", ADDR_W'(want.out_port), ADDR_W'(rsp_if.out_port));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
